[design/nearest_ray_sphere_hit_unit_defines.svh]
// Assertion macros for the nearest ray/sphere hit unit.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef NEAREST_RAY_SPHERE_HIT_UNIT_DEFINES_SVH
`define NEAREST_RAY_SPHERE_HIT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NRSH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nrsh assertion failed");
`define NRSH_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("nrsh assertion failed");
`else
`define NRSH_ASSERT_IMP(lbl, ante, cons)
`define NRSH_ASSERT_NEVER(lbl, cond)
`endif
`endif

[design/nrsh_pkg.sv]
// Package of the nearest ray/sphere hit unit: widths, codes, payload types.
// No dependencies.
`default_nettype none
package nrsh_pkg;

    localparam int COORD_W   = 32;
    localparam int ID_W      = 16;
    localparam int DIR_W     = 16;
    localparam int RAD_W     = 31;
    localparam int DIST_W    = 31;
    localparam int OC_W      = COORD_W + 1;
    localparam int MW        = 36;
    localparam int PW        = 2 * MW;
    localparam int MUL_CNT_W = $clog2(MW + 1);
    localparam int BS_W      = 50;
    localparam int B_W       = 37;
    localparam int C_W       = 68;
    localparam int DISC_W    = 74;
    localparam int S_W       = DISC_W / 2;
    localparam int SQ_CNT_W  = $clog2(S_W + 1);
    localparam int REM_W     = S_W + 2;
    localparam int T_W       = 39;
    localparam int CFG_IDX_W = 3;
    localparam int B_SHIFT   = 14;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = -16'sd16384;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_GO, S_MUL_WAIT, S_CULL, S_SQRT_GO, S_SQRT_WAIT, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_BX, OP_BY, OP_BZ, OP_SQX, OP_SQY, OP_SQZ, OP_R2, OP_B2
    } t_op;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          radius;
        logic [ID_W-1:0]           object_id;
        logic                      skip;
        logic                      last;
    } t_in;

    typedef struct packed {
        logic              hit_found;
        logic [ID_W-1:0]   hit_id;
        logic [DIST_W-1:0] hit_distance;
    } t_out;

    typedef struct packed {
        logic          start;
        logic [MW-1:0] a;
        logic [MW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [DISC_W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic           done;
        logic [S_W-1:0] root;
    } t_sqrt_rsp;

endpackage
`default_nettype wire

[design/nearest_ray_sphere_hit_unit.sv]
// Top level of the nearest ray/sphere hit unit: sequencer, accumulators, running minimum.
// Depends on nrsh_pkg, nrsh_mul, nrsh_isqrt and nearest_ray_sphere_hit_unit_defines.svh.
//
// Usage: write the ray origin (Q16.16) and unit direction (Q2.14) through i_cfg_we,
// i_cfg_index and i_cfg_wdata while the unit is idle; writes take effect at once.
// A candidate sphere transaction on i_data is taken at a clock edge with start high
// and busy low. busy stays high while the candidate is worked on.
// Per candidate: a skipped one goes straight to the done state.
// Otherwise seven products (b terms, squared offsets, radius squared) run on the
// shared bit-serial 36x36 multiplier, one after another; a sphere culled there
// ends. Then come b squared and the 37-step square root, which is not started
// when there is no real root.
// On a candidate marked last, o_result_valid pulses for one cycle, the first cycle
// after busy falls, with hit_found, hit_id and hit_distance, and the running minimum
// is cleared. The receiver cannot stall; the result is flagged valid for exactly that
// one cycle.
// Reset (synchronous, active low) returns the ray to origin zero, direction
// minus z, and clears the running minimum.
`default_nettype none
`include "nearest_ray_sphere_hit_unit_defines.svh"
module nearest_ray_sphere_hit_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  nrsh_pkg::t_in                       i_data,
    output logic                                o_result_valid,
    output nrsh_pkg::t_out                      o_result,
    input  logic                                i_cfg_we,
    input  logic [nrsh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nrsh_pkg::COORD_W-1:0]        i_cfg_wdata
);
    localparam int CW   = nrsh_pkg::COORD_W;
    localparam int DW   = nrsh_pkg::DIR_W;
    localparam int OCW  = nrsh_pkg::OC_W;
    localparam int MW   = nrsh_pkg::MW;
    localparam int BSW  = nrsh_pkg::BS_W;
    localparam int BW   = nrsh_pkg::B_W;
    localparam int CCW  = nrsh_pkg::C_W;
    localparam int DSW  = nrsh_pkg::DISC_W;
    localparam int TW   = nrsh_pkg::T_W;
    localparam int DSTW = nrsh_pkg::DIST_W;

    nrsh_pkg::t_state r_state, n_state;
    nrsh_pkg::t_op    r_op;
    nrsh_pkg::t_in    r_item;

    logic signed [CW-1:0] r_org [3];
    logic signed [DW-1:0] r_dir [3];

    logic signed [BSW-1:0]    r_bsum;
    logic signed [CCW-1:0]    r_c;
    logic [nrsh_pkg::PW-1:0]  r_b2;
    logic                     r_cand;
    logic [DSTW-1:0]          r_tq;

    logic [DSTW-1:0]          r_best_d;
    logic [nrsh_pkg::ID_W-1:0] r_best_id;
    logic                     r_any;

    nrsh_pkg::t_mul_req  mul_req;
    nrsh_pkg::t_mul_rsp  mul_rsp;
    nrsh_pkg::t_sqrt_req sq_req;
    nrsh_pkg::t_sqrt_rsp sq_rsp;

    logic signed [CW-1:0]  cen [3];
    logic signed [OCW-1:0] oc [3];
    logic [OCW-1:0]        oc_mag [3];
    logic [DW-1:0]         d_mag [3];
    logic                  term_neg;

    logic signed [BW-1:0]  b_val;
    logic [MW-1:0]         b_mag;
    logic                  b_pos;
    logic                  c_pos;
    logic signed [DSW-1:0] disc;
    logic                  disc_neg;

    logic signed [TW-1:0]  nb;
    logic signed [TW-1:0]  s_ext;
    logic signed [TW-1:0]  t_near;
    logic signed [TW-1:0]  t_far;
    logic signed [TW-1:0]  t_sel;
    logic                  t_ok;
    logic [DSTW-1:0]       t_sat;

    logic                  hit;
    logic [DSTW-1:0]       n_best_d;
    logic [nrsh_pkg::ID_W-1:0] n_best_id;
    logic                  n_any;
    logic                  accept;

    assign accept = start && !busy;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= nrsh_pkg::DIR_Z_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nrsh_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_wdata;
                nrsh_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_wdata;
                nrsh_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_wdata;
                nrsh_pkg::CFG_DIR_X:    r_dir[0] <= i_cfg_wdata[DW-1:0];
                nrsh_pkg::CFG_DIR_Y:    r_dir[1] <= i_cfg_wdata[DW-1:0];
                nrsh_pkg::CFG_DIR_Z:    r_dir[2] <= i_cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    assign cen[0] = r_item.center_x;
    assign cen[1] = r_item.center_y;
    assign cen[2] = r_item.center_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            oc[i]     = OCW'(r_org[i]) - OCW'(cen[i]);
            oc_mag[i] = oc[i][OCW-1] ? OCW'(-oc[i]) : OCW'(oc[i]);
            d_mag[i]  = r_dir[i][DW-1] ? DW'(-r_dir[i]) : DW'(r_dir[i]);
        end
    end

    assign b_val    = BW'(r_bsum >>> nrsh_pkg::B_SHIFT);
    assign b_mag    = b_val[BW-1] ? MW'(-b_val) : MW'(b_val);
    assign b_pos    = !b_val[BW-1] && (b_val != '0);
    assign c_pos    = !r_c[CCW-1] && (r_c != '0);
    assign disc     = $signed(DSW'(r_b2)) - DSW'(r_c);
    assign disc_neg = disc[DSW-1];

    // operand select for the shared multiplier
    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        term_neg  = 1'b0;
        unique case (r_op)
            nrsh_pkg::OP_BX: begin
                mul_req.a = MW'(oc_mag[0]);
                mul_req.b = MW'(d_mag[0]);
                term_neg  = oc[0][OCW-1] ^ r_dir[0][DW-1];
            end
            nrsh_pkg::OP_BY: begin
                mul_req.a = MW'(oc_mag[1]);
                mul_req.b = MW'(d_mag[1]);
                term_neg  = oc[1][OCW-1] ^ r_dir[1][DW-1];
            end
            nrsh_pkg::OP_BZ: begin
                mul_req.a = MW'(oc_mag[2]);
                mul_req.b = MW'(d_mag[2]);
                term_neg  = oc[2][OCW-1] ^ r_dir[2][DW-1];
            end
            nrsh_pkg::OP_SQX: begin
                mul_req.a = MW'(oc_mag[0]);
                mul_req.b = MW'(oc_mag[0]);
            end
            nrsh_pkg::OP_SQY: begin
                mul_req.a = MW'(oc_mag[1]);
                mul_req.b = MW'(oc_mag[1]);
            end
            nrsh_pkg::OP_SQZ: begin
                mul_req.a = MW'(oc_mag[2]);
                mul_req.b = MW'(oc_mag[2]);
            end
            nrsh_pkg::OP_R2: begin
                mul_req.a = MW'(r_item.radius);
                mul_req.b = MW'(r_item.radius);
            end
            nrsh_pkg::OP_B2: begin
                mul_req.a = b_mag;
                mul_req.b = b_mag;
            end
            default: ;
        endcase
    end

    // roots from the square root result
    assign nb     = -TW'(b_val);
    assign s_ext  = $signed(TW'(sq_rsp.root));
    assign t_near = nb - s_ext;
    assign t_far  = nb + s_ext;
    assign t_sel  = t_near[TW-1] ? t_far : t_near;
    assign t_ok   = !t_sel[TW-1];
    assign t_sat  = (t_sel[TW-2:DSTW] != '0) ? nrsh_pkg::DIST_MAX : t_sel[DSTW-1:0];

    assign sq_req.rad = DSW'(disc);

    nrsh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    nrsh_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nrsh_pkg::S_IDLE: begin
                if (start) n_state = i_data.skip ? nrsh_pkg::S_DONE : nrsh_pkg::S_MUL_GO;
            end
            nrsh_pkg::S_MUL_GO: n_state = nrsh_pkg::S_MUL_WAIT;
            nrsh_pkg::S_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    if (r_op == nrsh_pkg::OP_R2) n_state = nrsh_pkg::S_CULL;
                    else if (r_op == nrsh_pkg::OP_B2) n_state = nrsh_pkg::S_SQRT_GO;
                    else n_state = nrsh_pkg::S_MUL_GO;
                end
            end
            nrsh_pkg::S_CULL: begin
                n_state = (c_pos && b_pos) ? nrsh_pkg::S_DONE : nrsh_pkg::S_MUL_GO;
            end
            nrsh_pkg::S_SQRT_GO: begin
                n_state = disc_neg ? nrsh_pkg::S_DONE : nrsh_pkg::S_SQRT_WAIT;
            end
            nrsh_pkg::S_SQRT_WAIT: begin
                if (sq_rsp.done) n_state = nrsh_pkg::S_DONE;
            end
            nrsh_pkg::S_DONE: n_state = nrsh_pkg::S_IDLE;
            default: n_state = nrsh_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy          = 1'b1;
        mul_req.start = 1'b0;
        sq_req.start  = 1'b0;
        unique case (r_state)
            nrsh_pkg::S_IDLE:      busy = 1'b0;
            nrsh_pkg::S_MUL_GO:    mul_req.start = 1'b1;
            nrsh_pkg::S_SQRT_GO:   sq_req.start = !disc_neg;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= nrsh_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // per-candidate datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
            r_op   <= nrsh_pkg::OP_BX;
            r_bsum <= '0;
            r_c    <= '0;
            r_cand <= 1'b0;
        end
        if (r_state == nrsh_pkg::S_MUL_WAIT && mul_rsp.done) begin
            case (r_op) inside
                nrsh_pkg::OP_BX, nrsh_pkg::OP_BY, nrsh_pkg::OP_BZ: begin
                    r_bsum <= term_neg ? r_bsum - $signed(BSW'(mul_rsp.p))
                                       : r_bsum + $signed(BSW'(mul_rsp.p));
                end
                nrsh_pkg::OP_SQX, nrsh_pkg::OP_SQY, nrsh_pkg::OP_SQZ: begin
                    r_c <= r_c + $signed(CCW'(mul_rsp.p));
                end
                nrsh_pkg::OP_R2: r_c <= r_c - $signed(CCW'(mul_rsp.p));
                default: r_b2 <= mul_rsp.p;
            endcase
            if (r_op != nrsh_pkg::OP_R2 && r_op != nrsh_pkg::OP_B2) begin
                r_op <= nrsh_pkg::t_op'(3'(r_op) + 3'd1);
            end
        end
        if (r_state == nrsh_pkg::S_CULL) r_op <= nrsh_pkg::OP_B2;
        if (r_state == nrsh_pkg::S_SQRT_WAIT && sq_rsp.done) begin
            r_cand <= t_ok;
            r_tq   <= t_sat;
        end
    end

    // running minimum, earlier candidate wins ties
    assign hit       = (r_state == nrsh_pkg::S_DONE) && r_cand && (r_tq < r_best_d);
    assign n_best_d  = hit ? r_tq : r_best_d;
    assign n_best_id = hit ? r_item.object_id : r_best_id;
    assign n_any     = hit | r_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_d       <= nrsh_pkg::DIST_MAX;
            r_best_id      <= '0;
            r_any          <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (r_state == nrsh_pkg::S_DONE) begin
                if (r_item.last) begin
                    o_result_valid <= 1'b1;
                    r_best_d       <= nrsh_pkg::DIST_MAX;
                    r_best_id      <= '0;
                    r_any          <= 1'b0;
                end else begin
                    r_best_d  <= n_best_d;
                    r_best_id <= n_best_id;
                    r_any     <= n_any;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nrsh_pkg::S_DONE && r_item.last) begin
            o_result.hit_found    <= n_any;
            o_result.hit_id       <= n_any ? n_best_id : '0;
            o_result.hit_distance <= n_best_d;
        end
    end

    `NRSH_ASSERT_IMP(a_result_after_work, o_result_valid, $past(busy))
    `NRSH_ASSERT_NEVER(a_miss_id_zero, o_result_valid && !o_result.hit_found && o_result.hit_id != '0)
    `NRSH_ASSERT_NEVER(a_miss_dist_max, o_result_valid && !o_result.hit_found && o_result.hit_distance != nrsh_pkg::DIST_MAX)
    `NRSH_ASSERT_IMP(a_any_clears_on_emit, o_result_valid, !r_any && r_best_d == nrsh_pkg::DIST_MAX)
endmodule
`default_nettype wire

[design/nrsh_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nrsh_pkg.
`default_nettype none
module nrsh_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nrsh_pkg::t_mul_req i_req,
    output nrsh_pkg::t_mul_rsp o_rsp
);
    localparam int MW = nrsh_pkg::MW;
    localparam int PW = nrsh_pkg::PW;

    logic [PW-1:0]                  r_acc;
    logic [MW-1:0]                  r_a;
    logic [nrsh_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [MW:0]                    step_sum;

    assign step_sum = {1'b0, r_acc[PW-1:MW]} + (r_acc[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= nrsh_pkg::MUL_CNT_W'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == nrsh_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= {{MW{1'b0}}, i_req.b};
            r_a   <= i_req.a;
        end else if (r_busy) begin
            r_acc <= {step_sum, r_acc[MW-1:1]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;
endmodule
`default_nettype wire

[design/nrsh_isqrt.sv]
// Restoring floor square root, one result bit per cycle.
// Depends on nrsh_pkg.
`default_nettype none
module nrsh_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nrsh_pkg::t_sqrt_req i_req,
    output nrsh_pkg::t_sqrt_rsp o_rsp
);
    localparam int DW = nrsh_pkg::DISC_W;
    localparam int SW = nrsh_pkg::S_W;
    localparam int RW = nrsh_pkg::REM_W;

    logic [DW-1:0]                 r_rad;
    logic [RW-1:0]                 r_rem;
    logic [SW-1:0]                 r_root;
    logic [nrsh_pkg::SQ_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [RW-1:0]                 rem_sh;
    logic [RW-1:0]                 trial;
    logic                          take;

    assign rem_sh = {r_rem[RW-3:0], r_rad[DW-1:DW-2]};
    assign trial  = {r_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= nrsh_pkg::SQ_CNT_W'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == nrsh_pkg::SQ_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[DW-3:0], 2'b00};
            r_rem  <= take ? rem_sh - trial : rem_sh;
            r_root <= {r_root[SW-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;
endmodule
`default_nettype wire
